[rtl/core/hkr_pkg.sv]
package hkr_pkg;

  localparam int unsigned STEP_W = 10;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned FULL_W = 4;
  localparam int unsigned PART_W = 8;

  localparam int unsigned STEP_LIMIT   = 1023;
  localparam int unsigned RAMP_FULL_US = 2000000;
  localparam int unsigned RAMP_STEP_US = 200000;
  localparam int unsigned BAR_SEGS     = 11;
  localparam int unsigned FIX_BITS     = 16;
  localparam int unsigned PART_BITS    = 8;

  // partial-fill divider and ramp product geometry
  localparam int unsigned QUO_W      = 10;
  localparam int unsigned DIVISOR_W  = 21;
  localparam int unsigned DIVIDEND_W = 31;
  localparam int unsigned CNT_W      = $clog2(QUO_W);

  // elapsed*max / 2000000 as ((x >> 7) * ceil(2^38 / 15625)) >> 38, exact below 2^31
  localparam int unsigned HI_PRE    = 7;
  localparam int unsigned HI_SHIFT  = 38;
  localparam int unsigned RECIP_W   = 25;
  localparam int unsigned HI_FULL_W = DIVIDEND_W - HI_PRE + RECIP_W;
  localparam logic [RECIP_W-1:0] HI_RECIP = RECIP_W'(17592187);

  // bar scan arithmetic
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned PROD_W = 15;
  localparam int unsigned BND_W  = 12;
  localparam int unsigned DIV10_MUL = 52429;

  localparam logic [STEP_W-1:0] MAX_CAP =
      (STEP_LIMIT > (1 << STEP_W) - 1) ? {STEP_W{1'b1}} : STEP_W'(STEP_LIMIT);

  typedef enum logic [MODE_W-1:0] {
    MODE_UPDATE = 3'd0,
    MODE_UP     = 3'd1,
    MODE_DOWN   = 3'd2,
    MODE_STOP   = 3'd3,
    MODE_LOAD   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELAPSED,
    ST_MUL,
    ST_DIV_HI,
    ST_APPLY,
    ST_BAR_INIT,
    ST_BAR_SCAN,
    ST_PART_START,
    ST_DIV_PART,
    ST_SET_PART,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic calc_elapsed;
    logic mul_hi;
    logic div_hi;
    logic apply;
    logic bar_init;
    logic bar_scan;
    logic start_part;
    logic set_part;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_ramp;
    logic mx_zero;
    logic bar_done;
    logic need_part;
    logic div_done;
  } stat_t;

  function automatic logic [STEP_W-1:0] eff_max(input logic [STEP_W-1:0] m);
    return (m > MAX_CAP) ? MAX_CAP : m;
  endfunction

  // number of whole ramp steps elapsed, valid below the full ramp time
  function automatic logic [3:0] lo_steps(input logic [DIVISOR_W-1:0] d);
    logic [3:0] n;
    n = '0;
    for (int k = 1; k < 10; k++) begin
      if (d >= DIVISOR_W'(k * RAMP_STEP_US)) n = n + 4'd1;
    end
    return n;
  endfunction

  // x / 10 by reciprocal multiply, exact below 2^16
  function automatic logic [BND_W-2:0] div10(input logic [PROD_W-2:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'(DIV10_MUL);
    return p[29:19];
  endfunction

endpackage

[rtl/core/hkr_div.sv]
module hkr_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hkr_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [hkr_pkg::DIVISOR_W-1:0]   divisor,
  output logic [hkr_pkg::QUO_W-1:0]       quotient,
  output logic                            done
);
  import hkr_pkg::*;

  logic [DIVIDEND_W-1:0] rem;
  logic [DIVIDEND_W-1:0] dsh;
  logic [QUO_W-1:0]      quo;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  ge;

  assign ge = (rem >= dsh);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= DIVIDEND_W'(divisor) << (QUO_W - 1);
      quo <= '0;
    end else if (busy) begin
      if (ge) rem <= rem - dsh;
      quo <= {quo[QUO_W-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

endmodule

[rtl/core/hkr_ctrl.sv]
module hkr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  hkr_pkg::stat_t stat,
  output hkr_pkg::cmd_t  cmd
);
  import hkr_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:       if (in_valid) state_next = ST_ELAPSED;
      ST_ELAPSED:    state_next = stat.need_ramp ? ST_MUL : ST_BAR_INIT;
      ST_MUL:        state_next = ST_DIV_HI;
      ST_DIV_HI:     state_next = ST_APPLY;
      ST_APPLY:      state_next = ST_BAR_INIT;
      ST_BAR_INIT:   state_next = stat.mx_zero ? ST_FINISH : ST_BAR_SCAN;
      ST_BAR_SCAN:   if (stat.bar_done) state_next = ST_PART_START;
      ST_PART_START: state_next = stat.need_part ? ST_DIV_PART : ST_FINISH;
      ST_DIV_PART:   if (stat.div_done) state_next = ST_SET_PART;
      ST_SET_PART:   state_next = ST_FINISH;
      ST_FINISH:     if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_ELAPSED:    cmd.calc_elapsed = 1'b1;
      ST_MUL:        cmd.mul_hi = 1'b1;
      ST_DIV_HI:     cmd.div_hi = 1'b1;
      ST_APPLY:      cmd.apply = 1'b1;
      ST_BAR_INIT:   cmd.bar_init = 1'b1;
      ST_BAR_SCAN:   cmd.bar_scan = 1'b1;
      ST_PART_START: cmd.start_part = stat.need_part;
      ST_SET_PART:   cmd.set_part = 1'b1;
      ST_FINISH:     cmd.load_out = out_free;
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/hkr_datapath.sv]
module hkr_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  hkr_pkg::cmd_t               cmd,
  output hkr_pkg::stat_t              stat,
  input  logic [hkr_pkg::MODE_W-1:0]  mode,
  input  logic [hkr_pkg::TIME_W-1:0]  now_us,
  input  logic [hkr_pkg::STEP_W-1:0]  new_step,
  input  logic                        cfg_wr_en,
  input  logic [hkr_pkg::STEP_W-1:0]  cfg_wr_data,
  output logic [hkr_pkg::STEP_W-1:0]  current_step,
  output logic                        changed,
  output logic                        zooming,
  output logic                        enabled,
  output logic [hkr_pkg::FULL_W-1:0]  bar_full,
  output logic [hkr_pkg::PART_W-1:0]  bar_partial
);
  import hkr_pkg::*;

  // architectural state
  logic [STEP_W-1:0] max_steps;
  logic [STEP_W-1:0] step;
  dir_t              dir;
  logic [STEP_W-1:0] base;
  logic [TIME_W-1:0] start_time;

  // per-request working registers
  mode_t             mode_r;
  logic [TIME_W-1:0] now_r;
  logic [STEP_W-1:0] old_step;
  logic              chg;
  logic [TIME_W-1:0] elapsed;
  logic [3:0]        lo;
  logic [DIVIDEND_W-1:0] ramp_prod;
  logic [QUO_W-1:0]      hi_q;

  // bar scan registers
  logic signed [ROW_W-1:0]  row_k;
  logic signed [PROD_W-1:0] prod;
  logic signed [BND_W-1:0]  b0;
  logic signed [BND_W-1:0]  b1;
  logic [FULL_W-1:0]        full_r;
  logic [PART_W-1:0]        part_r;
  logic [STEP_W-1:0]        dsteps;
  logic signed [BND_W-1:0]  dmax;

  logic [STEP_W-1:0]     mx;
  logic [STEP_W-1:0]     step_up;
  logic [STEP_W-1:0]     step_dn;
  logic [STEP_W-1:0]     new_clamped;
  logic [STEP_W-1:0]     cfg_mx;
  logic [STEP_W-1:0]     delta;
  logic signed [11:0]    ramp_sum;
  logic [STEP_W-1:0]     step_apply;
  logic                  stop_apply;
  logic [HI_FULL_W-1:0]  hi_full;
  logic [PROD_W-2:0]     prod_mag;
  logic [BND_W-2:0]      bnd_mag;
  logic signed [BND_W-1:0] bk;
  logic signed [BND_W-1:0] cur_s;
  logic                  row_check;
  logic                  hit;

  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [QUO_W-1:0]      div_quo;
  logic                  div_done;

  assign mx          = eff_max(max_steps);
  assign cfg_mx      = eff_max(cfg_wr_data);
  assign step_up     = (step >= mx) ? mx : step + 1'b1;
  assign step_dn     = (step == '0) ? '0 : step - 1'b1;
  assign new_clamped = (new_step > mx) ? mx : new_step;

  // elapsed*max / 2000000 by reciprocal multiply
  assign hi_full = HI_FULL_W'(ramp_prod[DIVIDEND_W-1:HI_PRE]) * HI_FULL_W'(HI_RECIP);

  // ramp update from elapsed time, base and the larger of the two step counts
  assign delta    = (STEP_W'(lo) > hi_q) ? STEP_W'(lo) : hi_q;
  assign ramp_sum = (dir == DIR_UP) ? $signed({2'b00, base}) + $signed({2'b00, delta})
                                    : $signed({2'b00, base}) - $signed({2'b00, delta});

  always_comb begin
    step_apply = step;
    stop_apply = 1'b0;
    if ($signed(elapsed) >= $signed(TIME_W'(RAMP_FULL_US))) begin
      step_apply = (dir == DIR_UP) ? mx : '0;
      stop_apply = 1'b1;
    end else if (elapsed[TIME_W-1]) begin
      stop_apply = 1'b1;
    end else if (ramp_sum < 0) begin
      step_apply = '0;
      stop_apply = 1'b1;
    end else if (ramp_sum > $signed({2'b00, mx})) begin
      step_apply = mx;
      stop_apply = 1'b1;
    end else begin
      step_apply = ramp_sum[STEP_W-1:0];
    end
  end

  // segment boundary mx*k/10, truncated toward zero for the negative row
  assign prod_mag = prod[PROD_W-1] ? (PROD_W-1)'(-prod) : prod[PROD_W-2:0];
  assign bnd_mag  = div10(prod_mag);
  assign bk       = prod[PROD_W-1] ? -$signed({1'b0, bnd_mag}) : $signed({1'b0, bnd_mag});
  assign cur_s    = $signed({{(BND_W-STEP_W){1'b0}}, step});
  assign row_check = (row_k <= $signed(ROW_W'(BAR_SEGS - 2)));
  assign hit       = row_check && (cur_s >= b0) && (bk != b0);

  assign stat.need_ramp = (mode_r == MODE_UPDATE || mode_r == MODE_UP || mode_r == MODE_DOWN)
                          && (dir != DIR_NONE);
  assign stat.mx_zero   = (mx == '0);
  assign stat.bar_done  = hit || (row_k == -$signed(ROW_W'(1)));
  assign stat.need_part = (dsteps != '0) && (dmax > 0);
  assign stat.div_done  = div_done;

  assign div_start    = cmd.start_part;
  assign div_dividend = DIVIDEND_W'(dsteps) << PART_BITS;
  assign div_divisor  = DIVISOR_W'(dmax[BND_W-2:0]);

  hkr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_steps  <= '0;
      step       <= '0;
      dir        <= DIR_NONE;
      base       <= '0;
      start_time <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_steps <= cfg_wr_data;
        if (step > cfg_mx) step <= cfg_mx;
      end else if (cmd.accept) begin
        case (mode_t'(mode))
          MODE_UP: begin
            dir        <= DIR_UP;
            base       <= step_up;
            start_time <= now_us;
          end
          MODE_DOWN: begin
            dir        <= DIR_DOWN;
            base       <= step_dn;
            start_time <= now_us;
          end
          MODE_STOP: dir <= DIR_NONE;
          MODE_LOAD: step <= new_clamped;
          default: begin
          end
        endcase
      end else if (cmd.apply) begin
        step <= step_apply;
        if (stop_apply) dir <= DIR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r   <= mode_t'(mode);
      now_r    <= now_us;
      old_step <= step;
      chg      <= 1'b0;
    end
    if (cmd.calc_elapsed) elapsed <= now_r - start_time;
    if (cmd.mul_hi) begin
      lo        <= lo_steps(elapsed[DIVISOR_W-1:0]);
      ramp_prod <= DIVIDEND_W'(elapsed[DIVISOR_W-1:0]) * DIVIDEND_W'(mx);
    end
    if (cmd.div_hi) hi_q <= hi_full[HI_SHIFT +: QUO_W];
    if (cmd.apply) chg <= (step_apply != old_step);

    if (cmd.bar_init) begin
      row_k  <= ROW_W'(BAR_SEGS);
      prod   <= $signed(PROD_W'(mx) * PROD_W'(BAR_SEGS));
      full_r <= FULL_W'(1);
      part_r <= '0;
      dsteps <= '0;
      dmax   <= '0;
    end else if (cmd.bar_scan) begin
      b1    <= b0;
      b0    <= bk;
      prod  <= prod - $signed(PROD_W'(mx));
      row_k <= row_k - ROW_W'(1);
      if (hit) begin
        full_r <= FULL_W'(row_k + ROW_W'(2));
        dsteps <= STEP_W'(cur_s - b0);
        dmax   <= b1 - b0;
      end
    end
    if (cmd.set_part) part_r <= div_quo[PART_W-1:0];

    if (cmd.load_out) begin
      current_step <= step;
      changed      <= chg;
      zooming      <= (dir != DIR_NONE);
      enabled      <= (mx != '0);
      bar_full     <= full_r;
      bar_partial  <= part_r;
    end
  end

endmodule

[rtl/core/hold_key_ramp_with_bar_level.sv]
// a request is accepted in idle, then the elapsed time is taken; a running ramp adds the
// multiply, divide and apply steps, then the bar scan runs unless max_steps is zero, and a
// partial fill adds the divider; the result loads once the output register is free
// throughput: one request at a time, the next accepted the cycle after the result loads
// reset: synchronous active-high rst clears max_steps, the step, the ramp state and the
// handshake; results report enabled low until max_steps is written with a nonzero value
module hold_key_ramp_with_bar_level (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hkr_pkg::MODE_W-1:0]  mode,
  input  logic [hkr_pkg::TIME_W-1:0]  now_us,
  input  logic [hkr_pkg::STEP_W-1:0]  new_step,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hkr_pkg::STEP_W-1:0]  current_step,
  output logic                        changed,
  output logic                        zooming,
  output logic                        enabled,
  output logic [hkr_pkg::FULL_W-1:0]  bar_full,
  output logic [hkr_pkg::PART_W-1:0]  bar_partial,
  input  logic                        cfg_wr_en,
  input  logic [hkr_pkg::STEP_W-1:0]  cfg_wr_data
);
  import hkr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  hkr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hkr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .now_us       (now_us),
    .new_step     (new_step),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .current_step (current_step),
    .changed      (changed),
    .zooming      (zooming),
    .enabled      (enabled),
    .bar_full     (bar_full),
    .bar_partial  (bar_partial)
  );

endmodule

[tb/tb_hold_key_ramp_with_bar_level.sv]
`timescale 1ns / 1ps

module tb_hold_key_ramp_with_bar_level;
  import hkr_pkg::*;

  localparam longint FULL_US = RAMP_FULL_US;
  localparam longint STEP_US = RAMP_STEP_US;
  localparam int SEG_DIV = BAR_SEGS - 1;
  localparam int MODE_TOP = (1 << MODE_W) - 1;
  localparam int REQS_PER_PHASE = 110;
  localparam int REPORT_CAP = 40;

  typedef struct {
    logic [STEP_W-1:0] step;
    logic              changed;
    logic              zooming;
    logic              enabled;
    logic [FULL_W-1:0] full;
    logic [PART_W-1:0] part;
  } readout_t;

  class ramp_scoreboard;
    logic [STEP_W-1:0] max_reg;
    logic [STEP_W-1:0] step_now;
    logic [STEP_W-1:0] base_step;
    logic [TIME_W-1:0] start_t;
    dir_t              dir;
    readout_t          pending_readouts[$];
    int                mismatches;

    function new();
      max_reg = '0;
      step_now = '0;
      base_step = '0;
      start_t = '0;
      dir = DIR_NONE;
      mismatches = 0;
    endfunction

    function int top_step();
      return (int'(max_reg) > int'(STEP_LIMIT)) ? int'(STEP_LIMIT) : int'(max_reg);
    endfunction

    function int clamp_to(int v, int hi);
      if (v > hi) v = hi;
      if (v < 0) v = 0;
      return v;
    endfunction

    function void write_max(logic [STEP_W-1:0] v);
      max_reg = v;
      step_now = STEP_W'(clamp_to(int'(step_now), top_step()));
    endfunction

    function bit advance_ramp(logic [TIME_W-1:0] now);
      logic [STEP_W-1:0] old;
      logic [TIME_W-1:0] diff;
      longint el, lo, hi, delta, s;
      int mx;
      old = step_now;
      mx = top_step();
      if (dir != DIR_NONE) begin
        diff = now - start_t;
        el = longint'($signed(diff));
        if (el >= FULL_US) begin
          step_now = (dir == DIR_UP) ? STEP_W'(mx) : '0;
          dir = DIR_NONE;
        end else if (el < 0) begin
          dir = DIR_NONE;
        end else begin
          lo = el / STEP_US;
          hi = (el * mx) / FULL_US;
          delta = (lo > hi) ? lo : hi;
          s = (dir == DIR_UP) ? longint'(base_step) + delta : longint'(base_step) - delta;
          if (s < 0) begin
            s = 0;
            dir = DIR_NONE;
          end
          if (s > mx) begin
            s = mx;
            dir = DIR_NONE;
          end
          step_now = STEP_W'(s);
        end
      end
      return old != step_now;
    endfunction

    function void bar_readout(output logic [FULL_W-1:0] full, output logic [PART_W-1:0] part);
      int mx, cur, zs, prev, dsteps, dmax;
      bit hit;
      longint p;
      mx = top_step();
      cur = clamp_to(int'(step_now), mx);
      full = 1;
      part = 0;
      dsteps = 0;
      dmax = 0;
      hit = 0;
      if (mx > 0) begin
        // highest segment whose start the step has reached, skipping empty ones
        for (int row = SEG_DIV; row >= 0; row--) begin
          zs = (mx * row) / SEG_DIV;
          prev = (mx * (row - 1)) / SEG_DIV;
          if (!hit && cur >= zs && prev != zs) begin
            hit = 1;
            full = FULL_W'(row + 1);
            dsteps = cur - zs;
            dmax = (mx * (row + 1)) / SEG_DIV - zs;
          end
        end
        if (dsteps > 0 && dmax > 0) begin
          p = (longint'(dsteps) << FIX_BITS) / dmax;
          part = PART_W'(p >> (FIX_BITS - PART_BITS));
        end
      end
    endfunction

    function void note_request(logic [MODE_W-1:0] m, logic [TIME_W-1:0] now,
                               logic [STEP_W-1:0] ns);
      readout_t want;
      logic [FULL_W-1:0] f;
      logic [PART_W-1:0] pf;
      int mx;
      bit moved;
      mx = top_step();
      moved = 0;
      case (m)
        MODE_UPDATE: moved = advance_ramp(now);
        MODE_UP, MODE_DOWN: begin
          dir = (m == MODE_UP) ? DIR_UP : DIR_DOWN;
          base_step = STEP_W'(clamp_to(int'(step_now) + ((m == MODE_UP) ? 1 : -1), mx));
          start_t = now;
          moved = advance_ramp(now);
        end
        MODE_STOP: dir = DIR_NONE;
        MODE_LOAD: step_now = STEP_W'(clamp_to(int'(ns), mx));
        default: ;
      endcase
      bar_readout(f, pf);
      want.step = step_now;
      want.changed = moved;
      want.zooming = (dir != DIR_NONE);
      want.enabled = (mx > 0);
      want.full = f;
      want.part = pf;
      pending_readouts.push_back(want);
    endfunction

    function int pending();
      return pending_readouts.size();
    endfunction

    task report(string msg);
      if (mismatches < REPORT_CAP) $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(readout_t got);
      readout_t want;
      if (pending_readouts.size() == 0) begin
        report($sformatf("result with no request pending, step %0d", got.step));
      end else begin
        want = pending_readouts.pop_front();
        if (got.step !== want.step || got.changed !== want.changed ||
            got.zooming !== want.zooming || got.enabled !== want.enabled ||
            got.full !== want.full || got.part !== want.part)
          report($sformatf(
              "got/exp step %0d/%0d chg %b/%b zoom %b/%b en %b/%b full %0d/%0d part %0d/%0d",
              got.step, want.step, got.changed, want.changed, got.zooming, want.zooming,
              got.enabled, want.enabled, got.full, want.full, got.part, want.part));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [MODE_W-1:0] mode;
  logic [TIME_W-1:0] now_us;
  logic [STEP_W-1:0] new_step;
  logic              out_valid;
  logic              out_ready;
  logic [STEP_W-1:0] current_step;
  logic              changed;
  logic              zooming;
  logic              enabled;
  logic [FULL_W-1:0] bar_full;
  logic [PART_W-1:0] bar_partial;
  logic              cfg_wr_en;
  logic [STEP_W-1:0] cfg_wr_data;

  ramp_scoreboard    sb;
  int                rx_hold;
  bit                quiet;
  logic [STEP_W-1:0] cur_max;

  always #10 clk = ~clk;

  hold_key_ramp_with_bar_level dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .now_us       (now_us),
    .new_step     (new_step),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .current_step (current_step),
    .changed      (changed),
    .zooming      (zooming),
    .enabled      (enabled),
    .bar_full     (bar_full),
    .bar_partial  (bar_partial),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  task automatic send_request(logic [MODE_W-1:0] m, logic [TIME_W-1:0] t,
                              logic [STEP_W-1:0] ns);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    now_us <= t;
    new_step <= ns;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(m, t, ns);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_max(logic [STEP_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_max(v);
    cur_max = v;
  endtask

  // mostly press-then-update ramps with random content, plus loads, releases and noise
  task automatic random_traffic(int n);
    logic [MODE_W-1:0] m;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] press_t;
    logic [STEP_W-1:0] ns;
    int unsigned       offs;
    int                pick;
    int                sub;
    press_t = $urandom;
    offs = 0;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      ns = ($urandom_range(0, 1) == 1) ? STEP_W'($urandom_range(0, cur_max)) : STEP_W'($urandom);
      t = press_t + offs;
      if (pick < 12) begin
        m = ($urandom_range(0, 1) == 1) ? MODE_UP : MODE_DOWN;
        press_t = $urandom;
        offs = 0;
        t = press_t;
      end else if (pick < 74) begin
        m = MODE_UPDATE;
        sub = $urandom_range(0, 19);
        if (sub == 0) begin
          t = $urandom;
        end else if (sub == 1) begin
          t = press_t - $urandom_range(1, 5000);
        end else begin
          offs += $urandom_range(0, 300000);
          if (offs > 2300000) offs = $urandom_range(0, 100000);
          t = press_t + offs;
        end
      end else if (pick < 84) begin
        m = MODE_LOAD;
      end else if (pick < 92) begin
        m = MODE_STOP;
      end else begin
        m = MODE_W'($urandom_range(MODE_LOAD + 1, MODE_TOP));
      end
      send_request(m, t, ns);
    end
  endtask

  initial begin : rx_side
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_tap
    readout_t got;
    if (!rst && out_valid && out_ready) begin
      got.step = current_step;
      got.changed = changed;
      got.zooming = zooming;
      got.enabled = enabled;
      got.full = bar_full;
      got.part = bar_partial;
      sb.check_result(got);
    end
  end

  initial begin
    #(30_000_000);
    $display("hold_key_ramp_with_bar_level verification failed");
    $finish;
  end

  initial begin
    logic [STEP_W-1:0] max_plan[$];
    logic [TIME_W-1:0] t0;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_UPDATE;
    now_us = '0;
    new_step = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    rx_hold = 0;
    quiet = 0;
    cur_max = '0;
    t0 = 32'hFFFF_FF00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // disabled: presses arm the ramp but the step stays at zero
    send_request(MODE_UP, 32'h0, '0);
    send_request(MODE_UPDATE, TIME_W'(FULL_US), '0);
    send_request(MODE_DOWN, 32'h1234_5678, '1);
    send_request(MODE_LOAD, 32'h0, '1);
    send_request(MODE_W'(MODE_TOP), 32'hFFFF_FFFF, '1);
    settle();
    set_max('1);

    // start step clamps at both ends
    send_request(MODE_LOAD, 32'h0, '1);
    send_request(MODE_UP, t0, '0);
    send_request(MODE_LOAD, 32'h0, '0);
    send_request(MODE_DOWN, t0, '0);
    send_request(MODE_LOAD, 32'h0, 10'd500);
    send_request(MODE_UP, t0, '0);
    // elapsed time wraps through zero
    send_request(MODE_UPDATE, 32'h0001_0000, '0);
    send_request(MODE_UPDATE, t0 + 32'd1999999, '0);
    send_request(MODE_UPDATE, t0 + TIME_W'(FULL_US), '0);
    send_request(MODE_DOWN, 32'h8000_0000, '0);
    send_request(MODE_UPDATE, 32'h7FFF_FFFB, '0);
    send_request(MODE_UP, 32'h0000_1000, '0);
    send_request(MODE_STOP, 32'h0000_2000, '0);
    send_request(MODE_UPDATE, 32'h0010_0000, '0);
    send_request(MODE_W'(MODE_LOAD + 1), 32'h5555_5555, 10'h2AA);
    send_request(MODE_W'(MODE_LOAD + 2), 32'hAAAA_AAAA, 10'h155);
    // max lowered under a running ramp, next update lands above it
    send_request(MODE_LOAD, 32'h0, 10'd900);
    send_request(MODE_UP, 32'h4000_0000, '0);
    settle();
    set_max(10'd100);
    send_request(MODE_UPDATE, 32'h4000_0000 + 32'd50000, '0);

    max_plan.push_back('1);
    max_plan.push_back(10'd1);
    max_plan.push_back(10'd0);
    max_plan.push_back(10'd10);
    max_plan.push_back(10'd11);
    max_plan.push_back(10'd9);
    max_plan.push_back(10'd100);
    max_plan.push_back(STEP_W'($urandom));
    max_plan.push_back(STEP_W'($urandom));
    max_plan.push_back(STEP_W'($urandom));
    max_plan.push_back(10'd600);
    max_plan.push_back('1);
    foreach (max_plan[ph]) begin
      settle();
      set_max(max_plan[ph]);
      quiet = (ph % 4 == 3);
      // long receiver hold so the block backs up into the sender
      if (ph == 1) rx_hold = 500;
      random_traffic(REQS_PER_PHASE);
    end

    settle();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0)
      $display("hold_key_ramp_with_bar_level verification clean");
    else
      $display("hold_key_ramp_with_bar_level verification failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/hkr_pkg.sv
rtl/core/hkr_div.sv
rtl/core/hkr_ctrl.sv
rtl/core/hkr_datapath.sv
rtl/core/hold_key_ramp_with_bar_level.sv
tb/tb_hold_key_ramp_with_bar_level.sv
